// ===== hdl/dsgmw_pkg.sv =====
package dsgmw_pkg;

  localparam int TIME_BITS  = 32;
  localparam int COLOR_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int RATIO_BITS = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int OP_W       = 2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_IGNORE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd3;

  localparam logic [CFG_BITS-1:0]   WHITE_MAX_RST = 16'd60000;
  localparam logic [CFG_BITS-1:0]   BLACK_MIN_RST = 16'd100;
  localparam logic [RATIO_BITS-1:0] RATIO_RST     = 8'd102;
  localparam logic [CFG_BITS-1:0]   WINDOW_RST    = 16'd600;

  typedef struct packed {
    logic [CFG_BITS-1:0]   white_max;
    logic [CFG_BITS-1:0]   black_min;
    logic [RATIO_BITS-1:0] green_ratio;
    logic [CFG_BITS-1:0]   window_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dur;
    logic                 lg;
    logic                 rg;
  } cls_item_t;

  typedef struct packed {
    logic left_is_green;
    logic right_is_green;
    logic decision_ready;
    logic both_seen;
    logic only_left;
    logic only_right;
  } result_t;

endpackage

// ===== hdl/dsgmw_front.sv =====
module dsgmw_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dsgmw_pkg::cfg_t                     cfg_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [dsgmw_pkg::OP_W-1:0]          opcode_i,
  input  logic [dsgmw_pkg::TIME_BITS-1:0]     now_ms_i,
  input  logic [dsgmw_pkg::TIME_BITS-1:0]     ignore_duration_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_red_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_grn_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_blue_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_white_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_red_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_grn_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_blue_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_white_i,
  output logic                                mid_vld_o,
  output dsgmw_pkg::cls_item_t                mid_item_o,
  input  logic                                mid_take_i
);
  import dsgmw_pkg::*;

  localparam int SUM_W  = COLOR_BITS + 2;
  localparam int PROD_W = SUM_W + RATIO_BITS;

  function automatic logic is_green(input cfg_t c, input logic [COLOR_BITS-1:0] r,
                                    input logic [COLOR_BITS-1:0] g,
                                    input logic [COLOR_BITS-1:0] b,
                                    input logic [COLOR_BITS-1:0] w);
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    sum = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    lhs = PROD_W'({g, {RATIO_BITS{1'b0}}});
    rhs = PROD_W'(c.green_ratio) * PROD_W'(sum);
    return (w <= c.white_max) && (w >= c.black_min) && (sum != '0) && (lhs > rhs);
  endfunction

  cls_item_t             item_q [QDEPTH];
  logic [QPTR_W-1:0]     wr_q, wr_d;
  logic [QPTR_W-1:0]     rd_q, rd_d;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;
  cls_item_t             new_item;
  logic                  do_push;
  logic                  is_sample;

  assign is_sample = (opcode_i == OP_SAMPLE);

  always_comb begin
    new_item.op  = opcode_i;
    new_item.now = now_ms_i;
    new_item.dur = ignore_duration_i;
    new_item.lg  = is_sample && is_green(cfg_i, left_red_i, left_grn_i, left_blue_i,
                                         left_white_i);
    new_item.rg  = is_sample && is_green(cfg_i, right_red_i, right_grn_i, right_blue_i,
                                         right_white_i);
  end

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push    = push_i && !full_o;
  assign mid_vld_o  = (cnt_q != '0);
  assign mid_item_o = item_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = mid_take_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(do_push) - QCNT_W'(mid_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_q[wr_q] <= new_item;
    end
  end

endmodule

// ===== hdl/dsgmw_back.sv =====
module dsgmw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsgmw_pkg::cfg_t       cfg_i,
  input  logic                  mid_vld_i,
  input  dsgmw_pkg::cls_item_t  mid_item_i,
  output logic                  mid_take_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output dsgmw_pkg::result_t    res_o
);
  import dsgmw_pkg::*;

  logic                 seen_l_q, seen_l_d;
  logic                 seen_r_q, seen_r_d;
  logic                 open_q, open_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [TIME_BITS-1:0] ign_q, ign_d;
  logic [TIME_BITS-1:0] elapsed;
  result_t              res;

  result_t              res_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_q, wr_d;
  logic [QPTR_W-1:0]    rd_q, rd_d;
  logic [QCNT_W-1:0]    cnt_q, cnt_d;
  logic                 do_pop;

  assign mid_take_o = mid_vld_i && (cnt_q != QCNT_W'(QDEPTH));

  always_comb begin
    seen_l_d = seen_l_q;
    seen_r_d = seen_r_q;
    open_d   = open_q;
    start_d  = start_q;
    ign_d    = ign_q;
    unique case (mid_item_i.op)
      OP_SAMPLE: begin
        if (mid_item_i.now < ign_q) begin
          seen_l_d = 1'b0;
          seen_r_d = 1'b0;
          open_d   = 1'b0;
          start_d  = '0;
        end else if (mid_item_i.lg || mid_item_i.rg) begin
          if (mid_item_i.lg) seen_l_d = 1'b1;
          if (mid_item_i.rg) seen_r_d = 1'b1;
          if (!open_q) begin
            open_d  = 1'b1;
            start_d = mid_item_i.now;
          end
        end
      end
      OP_CLEAR: begin
        seen_l_d = 1'b0;
        seen_r_d = 1'b0;
        open_d   = 1'b0;
        start_d  = '0;
      end
      OP_IGNORE: begin
        seen_l_d = 1'b0;
        seen_r_d = 1'b0;
        open_d   = 1'b0;
        start_d  = '0;
        ign_d    = mid_item_i.now + mid_item_i.dur;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    elapsed            = mid_item_i.now - start_d;
    res.left_is_green  = mid_item_i.lg;
    res.right_is_green = mid_item_i.rg;
    res.decision_ready = open_d && ((seen_l_d && seen_r_d) ||
                                    (elapsed > TIME_BITS'(cfg_i.window_ms)));
    res.both_seen      = seen_l_d && seen_r_d;
    res.only_left      = seen_l_d && !seen_r_d;
    res.only_right     = !seen_l_d && seen_r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_l_q <= 1'b0;
      seen_r_q <= 1'b0;
      open_q   <= 1'b0;
      start_q  <= '0;
      ign_q    <= '0;
    end else if (mid_take_o) begin
      seen_l_q <= seen_l_d;
      seen_r_q <= seen_r_d;
      open_q   <= open_d;
      start_q  <= start_d;
      ign_q    <= ign_d;
    end
  end

  // result queue
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = res_q[rd_q];

  always_comb begin
    wr_d  = mid_take_o ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(mid_take_o) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_take_o) begin
      res_q[wr_q] <= res;
    end
  end

endmodule

// ===== hdl/dual_sensor_green_marker_window.sv =====
// channel   signals                                   moves
// --------  ----------------------------------------  ------------------------------
// input     push, full, opcode_i .. right_white_i     one item per push && !full
// result    empty, pop, left_is_green_o .. only_right_o  one item per pop && !empty
// config    cfg_we_i, cfg_idx_i, cfg_data_i           one register write per cfg_we_i
//
// one item per cycle while no queue fills; items pass the front queue, then the result queue
// front classifies and queues (2 entries), back updates flags and queues results (2 entries)
// either side may stall without stopping the other until its queue fills
// reset clears flags, window, ignore time and both queues; registers return to defaults
module dual_sensor_green_marker_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsgmw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dsgmw_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [dsgmw_pkg::OP_W-1:0]          opcode_i,
  input  logic [dsgmw_pkg::TIME_BITS-1:0]     now_ms_i,
  input  logic [dsgmw_pkg::TIME_BITS-1:0]     ignore_duration_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_red_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_grn_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_blue_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    left_white_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_red_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_grn_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_blue_i,
  input  logic [dsgmw_pkg::COLOR_BITS-1:0]    right_white_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                left_is_green_o,
  output logic                                right_is_green_o,
  output logic                                decision_ready_o,
  output logic                                both_seen_o,
  output logic                                only_left_o,
  output logic                                only_right_o
);
  import dsgmw_pkg::*;

  cfg_t      cfg_q, cfg_d;
  logic      mid_vld;
  cls_item_t mid_item;
  logic      mid_take;
  result_t   res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WHITE_MAX: cfg_d.white_max   = cfg_data_i;
        CFG_BLACK_MIN: cfg_d.black_min   = cfg_data_i;
        CFG_RATIO:     cfg_d.green_ratio = cfg_data_i[RATIO_BITS-1:0];
        CFG_WINDOW:    cfg_d.window_ms   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.white_max   <= WHITE_MAX_RST;
      cfg_q.black_min   <= BLACK_MIN_RST;
      cfg_q.green_ratio <= RATIO_RST;
      cfg_q.window_ms   <= WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dsgmw_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .push_i            (push),
    .full_o            (full),
    .opcode_i          (opcode_i),
    .now_ms_i          (now_ms_i),
    .ignore_duration_i (ignore_duration_i),
    .left_red_i        (left_red_i),
    .left_grn_i        (left_grn_i),
    .left_blue_i       (left_blue_i),
    .left_white_i      (left_white_i),
    .right_red_i       (right_red_i),
    .right_grn_i       (right_grn_i),
    .right_blue_i      (right_blue_i),
    .right_white_i     (right_white_i),
    .mid_vld_o         (mid_vld),
    .mid_item_o        (mid_item),
    .mid_take_i        (mid_take)
  );

  dsgmw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .mid_vld_i  (mid_vld),
    .mid_item_i (mid_item),
    .mid_take_o (mid_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign left_is_green_o  = res.left_is_green;
  assign right_is_green_o = res.right_is_green;
  assign decision_ready_o = res.decision_ready;
  assign both_seen_o      = res.both_seen;
  assign only_left_o      = res.only_left;
  assign only_right_o     = res.only_right;

endmodule

// ===== test/tb.sv =====
module tb;
  import dsgmw_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEMS_PER_SETTING = 165;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] grn;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] white;
  } rgbw_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] dur;
    rgbw_t                left;
    rgbw_t                right;
  } marker_item_t;

  // red, grn, blue, white
  localparam rgbw_t GREEN_RGBW = {16'd100, 16'd200, 16'd100, 16'd1000};
  localparam rgbw_t DARK_RGBW  = {16'd100, 16'd200, 16'd100, 16'd50};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_BITS-1:0]   cfg_data_i;
  logic                  push;
  logic                  full;
  logic [OP_W-1:0]       opcode_i;
  logic [TIME_BITS-1:0]  now_ms_i;
  logic [TIME_BITS-1:0]  ignore_duration_i;
  logic [COLOR_BITS-1:0] left_red_i;
  logic [COLOR_BITS-1:0] left_grn_i;
  logic [COLOR_BITS-1:0] left_blue_i;
  logic [COLOR_BITS-1:0] left_white_i;
  logic [COLOR_BITS-1:0] right_red_i;
  logic [COLOR_BITS-1:0] right_grn_i;
  logic [COLOR_BITS-1:0] right_blue_i;
  logic [COLOR_BITS-1:0] right_white_i;
  logic                  empty;
  logic                  pop;
  logic                  left_is_green_o;
  logic                  right_is_green_o;
  logic                  decision_ready_o;
  logic                  both_seen_o;
  logic                  only_left_o;
  logic                  only_right_o;

  // predictor copy of registers and marker state
  cfg_t                 cur_cfg;
  logic                 seen_l;
  logic                 seen_r;
  logic                 win_open;
  logic [TIME_BITS-1:0] win_start;
  logic [TIME_BITS-1:0] quiet_end;

  result_t              marker_q[$];
  int                   n_fail;
  int                   quiet_cycles;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  logic [TIME_BITS-1:0] clock_ms;

  dual_sensor_green_marker_window u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .opcode_i         (opcode_i),
    .now_ms_i         (now_ms_i),
    .ignore_duration_i(ignore_duration_i),
    .left_red_i       (left_red_i),
    .left_grn_i       (left_grn_i),
    .left_blue_i      (left_blue_i),
    .left_white_i     (left_white_i),
    .right_red_i      (right_red_i),
    .right_grn_i      (right_grn_i),
    .right_blue_i     (right_blue_i),
    .right_white_i    (right_white_i),
    .empty            (empty),
    .pop              (pop),
    .left_is_green_o  (left_is_green_o),
    .right_is_green_o (right_is_green_o),
    .decision_ready_o (decision_ready_o),
    .both_seen_o      (both_seen_o),
    .only_left_o      (only_left_o),
    .only_right_o     (only_right_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic is_green(rgbw_t c);
    logic [31:0] sum;
    logic [31:0] lhs;
    logic [31:0] rhs;
    sum = 32'(c.red) + 32'(c.grn) + 32'(c.blue);
    lhs = 32'(c.grn) << 8;
    rhs = 32'(cur_cfg.green_ratio) * sum;
    if (c.white > cur_cfg.white_max) return 1'b0;
    if (c.white < cur_cfg.black_min) return 1'b0;
    if (sum == 0) return 1'b0;
    return lhs > rhs;
  endfunction

  function automatic void drop_flags();
    seen_l = 1'b0;
    seen_r = 1'b0;
    win_open = 1'b0;
    win_start = '0;
  endfunction

  function automatic void open_window(logic [TIME_BITS-1:0] now);
    if (!win_open) begin
      win_open = 1'b1;
      win_start = now;
    end
  endfunction

  function automatic result_t advance_window(marker_item_t it);
    result_t              r;
    logic [TIME_BITS-1:0] elapsed;
    r = '0;
    case (it.op)
      OP_SAMPLE: begin
        r.left_is_green = is_green(it.left);
        r.right_is_green = is_green(it.right);
        if (it.now < quiet_end) begin
          drop_flags();
        end else begin
          if (r.left_is_green) begin
            seen_l = 1'b1;
            open_window(it.now);
          end
          if (r.right_is_green) begin
            seen_r = 1'b1;
            open_window(it.now);
          end
        end
      end
      OP_CLEAR: drop_flags();
      OP_IGNORE: begin
        drop_flags();
        quiet_end = it.now + it.dur;
      end
      default: ;
    endcase
    if (win_open) begin
      elapsed = it.now - win_start;
      r.decision_ready = (seen_l && seen_r) || (elapsed > TIME_BITS'(cur_cfg.window_ms));
    end
    r.both_seen = seen_l && seen_r;
    r.only_left = seen_l && !seen_r;
    r.only_right = !seen_l && seen_r;
    return r;
  endfunction

  function automatic void check_bit(string field, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      n_fail++;
    end
  endfunction

  function automatic marker_item_t reading(logic [TIME_BITS-1:0] now, rgbw_t l, rgbw_t r);
    marker_item_t it;
    it.op = OP_SAMPLE;
    it.now = now;
    it.dur = $urandom;
    it.left = l;
    it.right = r;
    return it;
  endfunction

  function automatic marker_item_t command(logic [OP_W-1:0] op, logic [TIME_BITS-1:0] now,
                                           logic [TIME_BITS-1:0] dur);
    marker_item_t it;
    it.op = op;
    it.now = now;
    it.dur = dur;
    it.left = {$urandom, $urandom};
    it.right = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [COLOR_BITS-1:0] pick_white();
    if (cur_cfg.black_min <= cur_cfg.white_max) begin
      return COLOR_BITS'($urandom_range(cur_cfg.white_max, cur_cfg.black_min));
    end
    return COLOR_BITS'($urandom);
  endfunction

  function automatic rgbw_t random_rgbw();
    rgbw_t       c;
    int unsigned s;
    int unsigned g;
    int unsigned rest;
    c = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1: ;
      2: begin
        c.red = '0;
        c.grn = '0;
        c.blue = '0;
      end
      3, 4, 5, 6, 7: begin
        c.grn = COLOR_BITS'($urandom_range(65535, 256));
        c.red = COLOR_BITS'($urandom_range(c.grn >> 2));
        c.blue = COLOR_BITS'($urandom_range(c.grn >> 2));
        c.white = pick_white();
      end
      default: begin
        // near the green share threshold
        s = $urandom_range(4000, 1);
        g = ((32'(cur_cfg.green_ratio) * s) >> 8) + $urandom_range(1);
        if (g > s) g = s;
        rest = s - g;
        c.grn = COLOR_BITS'(g);
        c.red = COLOR_BITS'($urandom_range(rest));
        c.blue = COLOR_BITS'(rest - 32'(c.red));
        c.white = pick_white();
      end
    endcase
    return c;
  endfunction

  function automatic marker_item_t random_item();
    marker_item_t it;
    int unsigned  span;
    int unsigned  pick;
    span = cur_cfg.window_ms / 2 + 2;
    if ($urandom_range(99) < 5) clock_ms = $urandom;
    else clock_ms += $urandom_range(span);
    it.now = clock_ms;
    it.dur = $urandom;
    it.left = random_rgbw();
    it.right = random_rgbw();
    pick = $urandom_range(99);
    if (pick < 82) begin
      it.op = OP_SAMPLE;
    end else if (pick < 90) begin
      it.op = OP_CLEAR;
    end else if (pick < 98) begin
      it.op = OP_IGNORE;
      if ($urandom_range(3) != 0) it.dur = $urandom_range(4 * span);
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(marker_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= it.op;
    now_ms_i <= it.now;
    ignore_duration_i <= it.dur;
    left_red_i <= it.left.red;
    left_grn_i <= it.left.grn;
    left_blue_i <= it.left.blue;
    left_white_i <= it.left.white;
    right_red_i <= it.right.red;
    right_grn_i <= it.right.grn;
    right_blue_i <= it.right.blue;
    right_white_i <= it.right.white;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    marker_q.push_back(advance_window(it));
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (marker_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WHITE_MAX;
    cfg_data_i <= c.white_max;
    @(posedge clk_i);
    cur_cfg.white_max = c.white_max;
    cfg_idx_i <= CFG_BLACK_MIN;
    cfg_data_i <= c.black_min;
    @(posedge clk_i);
    cur_cfg.black_min = c.black_min;
    cfg_idx_i <= CFG_RATIO;
    cfg_data_i <= CFG_BITS'(c.green_ratio);
    @(posedge clk_i);
    cur_cfg.green_ratio = c.green_ratio;
    cfg_idx_i <= CFG_WINDOW;
    cfg_data_i <= c.window_ms;
    @(posedge clk_i);
    cur_cfg.window_ms = c.window_ms;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_classification();
    send_item(reading(32'd0, '0, '0));
    send_item(reading(32'd10, '1, '1));
    send_item(reading(32'd100, GREEN_RGBW, DARK_RGBW));
    // elapsed equal to the window is not yet ready
    send_item(reading(32'd700, DARK_RGBW, DARK_RGBW));
    send_item(reading(32'd701, DARK_RGBW, DARK_RGBW));
    send_item(reading(32'd710, DARK_RGBW, GREEN_RGBW));
    send_item(command(OP_CLEAR, 32'd720, $urandom));
    // white exactly at both limits
    send_item(reading(32'd800, {16'd100, 16'd200, 16'd100, 16'd60000},
                      {16'd100, 16'd200, 16'd100, 16'd100}));
    send_item(reading(32'd810, {16'd100, 16'd200, 16'd100, 16'd99},
                      {16'd100, 16'd200, 16'd100, 16'd60001}));
    send_item(command(OP_CLEAR, 32'd820, $urandom));
    // green share equal to the ratio, then one above
    send_item(reading(32'd830, {16'd154, 16'd102, 16'd0, 16'd1000},
                      {16'd153, 16'd103, 16'd0, 16'd1000}));
    send_item(reading(32'd840, {16'd0, 16'd0, 16'd0, 16'd1000},
                      {16'd0, 16'd65535, 16'd0, 16'd1000}));
    wait_results_drained();
  endtask

  task automatic test_ignore_and_wrap();
    send_item(command(OP_IGNORE, 32'd1000, 32'd500));
    send_item(reading(32'd1200, GREEN_RGBW, GREEN_RGBW));
    send_item(reading(32'd1499, GREEN_RGBW, GREEN_RGBW));
    send_item(reading(32'd1500, GREEN_RGBW, GREEN_RGBW));
    send_item(command(OP_UNUSED, 32'd1600, $urandom));
    // ignore end wraps past zero
    send_item(command(OP_IGNORE, 32'hFFFF_FF00, 32'h0000_0200));
    send_item(reading(32'hFFFF_FF80, GREEN_RGBW, DARK_RGBW));
    send_item(reading(32'h0000_0300, DARK_RGBW, DARK_RGBW));
    send_item(command(OP_IGNORE, 32'h0000_0300, 32'hFFFF_FFFF));
    send_item(reading(32'h0000_02FE, GREEN_RGBW, GREEN_RGBW));
    send_item(reading(32'h0000_02FF, GREEN_RGBW, GREEN_RGBW));
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 85 : 0;
      recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 7 : 0;
      for (int k = 0; k < 2; k++) begin
        case (mode * 2 + k)
          0: c = {WHITE_MAX_RST, BLACK_MIN_RST, RATIO_RST, WINDOW_RST};
          1: c = '0;
          2: c = '1;
          3: begin
            c.white_max = CFG_BITS'($urandom);
            c.black_min = CFG_BITS'($urandom);
            c.green_ratio = RATIO_BITS'($urandom);
            c.window_ms = CFG_BITS'($urandom);
          end
          4: begin
            c.white_max = CFG_BITS'($urandom_range(65535, 30000));
            c.black_min = CFG_BITS'($urandom_range(500));
            c.green_ratio = RATIO_BITS'($urandom);
            c.window_ms = CFG_BITS'($urandom_range(50));
          end
          default: begin
            c.white_max = '1;
            c.black_min = '0;
            c.green_ratio = RATIO_BITS'($urandom);
            c.window_ms = CFG_BITS'($urandom);
          end
        endcase
        load_config(c);
        repeat (ITEMS_PER_SETTING) send_item(random_item());
        wait_results_drained();
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (marker_q.size() == 0) begin
        $error("result with no item waiting");
        n_fail++;
      end else begin
        want = marker_q.pop_front();
        check_bit("left_is_green", want.left_is_green, left_is_green_o);
        check_bit("right_is_green", want.right_is_green, right_is_green_o);
        check_bit("decision_ready", want.decision_ready, decision_ready_o);
        check_bit("both_seen", want.both_seen, both_seen_o);
        check_bit("only_left", want.only_left, only_left_o);
        check_bit("only_right", want.only_right, only_right_o);
      end
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    n_fail = 0;
    send_idle_pct = 7;
    recv_idle_pct = 85;
    clock_ms = '0;
    cur_cfg = {WHITE_MAX_RST, BLACK_MIN_RST, RATIO_RST, WINDOW_RST};
    drop_flags();
    quiet_end = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_WHITE_MAX;
    cfg_data_i <= '0;
    push <= 1'b0;
    opcode_i <= OP_SAMPLE;
    now_ms_i <= '0;
    ignore_duration_i <= '0;
    left_red_i <= '0;
    left_grn_i <= '0;
    left_blue_i <= '0;
    left_white_i <= '0;
    right_red_i <= '0;
    right_grn_i <= '0;
    right_blue_i <= '0;
    right_white_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_classification();
    test_ignore_and_wrap();
    test_random_traffic();

    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
